// ===== src/ehtok_pkg.sv =====
// ----------------------------------------------------------------------------
// ehtok_pkg
// Shared types and constants for the envelope header tokenizer.
// ----------------------------------------------------------------------------
package ehtok_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_KEY   = 3'd1,
    PH_SKIP  = 3'd2,
    PH_VALUE = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    K_KEY   = 3'd0,
    K_VALUE = 3'd1,
    K_HDR   = 3'd2,
    K_END   = 3'd3,
    K_ERR   = 3'd4
  } kind_t;

  typedef struct packed {
    phase_t phase;
    logic   cr_pending;
    logic   header_open;
    logic   line_first_pending;
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]         count;
    result_t [1:0]      res;
  } pair_t;

  function automatic pair_t push(pair_t p, kind_t k, logic [7:0] d);
    pair_t q;
    q = p;
    q.res[p.count[0]].kind = k;
    q.res[p.count[0]].data = d;
    q.res[p.count[0]].last = 1'b0;
    q.count = p.count + 2'd1;
    return q;
  endfunction

endpackage

// ===== src/ehtok_decode.sv =====
// ----------------------------------------------------------------------------
// ehtok_decode
// Per-byte tokenizer step: next state and up to two results for one item.
// ----------------------------------------------------------------------------
module ehtok_decode (
  input  ehtok_pkg::state_t st,
  input  logic [7:0]        b,
  output ehtok_pkg::state_t st_nxt,
  output ehtok_pkg::pair_t  res
);

  logic is_cr;
  logic is_lf;
  logic is_colon;

  assign is_cr    = (b == ehtok_pkg::CH_CR);
  assign is_lf    = (b == ehtok_pkg::CH_LF);
  assign is_colon = (b == ehtok_pkg::CH_COLON);

  // next state
  always_comb begin
    st_nxt = st;
    case (st.phase)
      ehtok_pkg::PH_START: begin
        if (st.line_first_pending) begin
          st_nxt.line_first_pending = 1'b0;
          if (is_lf) begin
            st_nxt.header_open = 1'b0;
            st_nxt.phase       = ehtok_pkg::PH_DONE;
          end else if (!st.header_open) begin
            st_nxt.phase      = ehtok_pkg::PH_DONE;
            st_nxt.cr_pending = 1'b0;
          end else begin
            st_nxt.phase      = ehtok_pkg::PH_VALUE;
            st_nxt.cr_pending = is_cr;
          end
        end else if (is_cr) begin
          st_nxt.line_first_pending = 1'b1;
        end else if (b <= ehtok_pkg::CH_SPACE) begin
          if (!st.header_open) begin
            st_nxt.phase      = ehtok_pkg::PH_DONE;
            st_nxt.cr_pending = 1'b0;
          end else begin
            st_nxt.phase = ehtok_pkg::PH_VALUE;
          end
        end else if (is_colon) begin
          st_nxt.header_open = 1'b0;
          st_nxt.phase       = ehtok_pkg::PH_SKIP;
        end else begin
          st_nxt.header_open = 1'b1;
          st_nxt.phase       = ehtok_pkg::PH_KEY;
        end
      end
      ehtok_pkg::PH_KEY: begin
        if (st.cr_pending && is_lf) begin
          st_nxt.phase              = ehtok_pkg::PH_DONE;
          st_nxt.cr_pending         = 1'b0;
          st_nxt.line_first_pending = 1'b0;
        end else begin
          st_nxt.cr_pending = is_cr;
          if (!is_cr && is_colon) begin
            st_nxt.phase = ehtok_pkg::PH_SKIP;
          end
        end
      end
      ehtok_pkg::PH_SKIP: begin
        if (st.cr_pending) begin
          if (is_lf) begin
            st_nxt.phase              = ehtok_pkg::PH_START;
            st_nxt.cr_pending         = 1'b0;
            st_nxt.line_first_pending = 1'b0;
          end else begin
            st_nxt.phase      = ehtok_pkg::PH_VALUE;
            st_nxt.cr_pending = is_cr;
          end
        end else if (is_cr) begin
          st_nxt.cr_pending = 1'b1;
        end else begin
          st_nxt.phase = ehtok_pkg::PH_VALUE;
        end
      end
      ehtok_pkg::PH_VALUE: begin
        if (st.cr_pending && is_lf) begin
          st_nxt.phase              = ehtok_pkg::PH_START;
          st_nxt.cr_pending         = 1'b0;
          st_nxt.line_first_pending = 1'b0;
        end else begin
          st_nxt.cr_pending = is_cr;
        end
      end
      default: begin
        st_nxt.phase = ehtok_pkg::PH_DONE;
      end
    endcase
  end

  // results
  always_comb begin
    ehtok_pkg::pair_t p;
    p = '0;
    case (st.phase)
      ehtok_pkg::PH_START: begin
        if (st.line_first_pending) begin
          if (is_lf) begin
            if (st.header_open) begin
              p = ehtok_pkg::push(p, ehtok_pkg::K_HDR, 8'd0);
            end
            p = ehtok_pkg::push(p, ehtok_pkg::K_END, 8'd0);
          end else if (!st.header_open) begin
            p = ehtok_pkg::push(p, ehtok_pkg::K_ERR, 8'd0);
          end else begin
            p = ehtok_pkg::push(p, ehtok_pkg::K_VALUE, ehtok_pkg::CH_CR);
            if (!is_cr) begin
              p = ehtok_pkg::push(p, ehtok_pkg::K_VALUE, b);
            end
          end
        end else if (is_cr) begin
          p = '0;
        end else if (b <= ehtok_pkg::CH_SPACE) begin
          if (!st.header_open) begin
            p = ehtok_pkg::push(p, ehtok_pkg::K_ERR, 8'd0);
          end else begin
            p = ehtok_pkg::push(p, ehtok_pkg::K_VALUE, b);
          end
        end else begin
          if (st.header_open) begin
            p = ehtok_pkg::push(p, ehtok_pkg::K_HDR, 8'd0);
          end
          if (!is_colon) begin
            p = ehtok_pkg::push(p, ehtok_pkg::K_KEY, b);
          end
        end
      end
      ehtok_pkg::PH_KEY: begin
        if (st.cr_pending && is_lf) begin
          p = ehtok_pkg::push(p, ehtok_pkg::K_ERR, 8'd0);
        end else begin
          if (st.cr_pending) begin
            p = ehtok_pkg::push(p, ehtok_pkg::K_KEY, ehtok_pkg::CH_CR);
          end
          if (!is_cr && !is_colon) begin
            p = ehtok_pkg::push(p, ehtok_pkg::K_KEY, b);
          end
        end
      end
      ehtok_pkg::PH_SKIP: begin
        if (st.cr_pending && !is_lf && !is_cr && st.header_open) begin
          p = ehtok_pkg::push(p, ehtok_pkg::K_VALUE, b);
        end
      end
      ehtok_pkg::PH_VALUE: begin
        if (!(st.cr_pending && is_lf) && st.header_open) begin
          if (st.cr_pending) begin
            p = ehtok_pkg::push(p, ehtok_pkg::K_VALUE, ehtok_pkg::CH_CR);
          end
          if (!is_cr) begin
            p = ehtok_pkg::push(p, ehtok_pkg::K_VALUE, b);
          end
        end
      end
      default: begin
        p = '0;
      end
    endcase
    if (p.count == 2'd1) begin
      p.res[0].last = 1'b1;
    end else if (p.count == 2'd2) begin
      p.res[1].last = 1'b1;
    end
    res = p;
  end

endmodule

// ===== src/ehtok_queue.sv =====
// ----------------------------------------------------------------------------
// ehtok_queue
// Four-entry result queue; takes up to two results per cycle, and while out_ready is high gives one.
// ----------------------------------------------------------------------------
module ehtok_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_en,
  input  ehtok_pkg::pair_t  push_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output ehtok_pkg::result_t out_data
);

  ehtok_pkg::result_t mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] n_push;
  logic       pop;

  assign n_push    = push_en ? push_data.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 3'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign room      = (count_r <= 3'd2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, n_push} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= push_data.res[0];
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push_data.res[1];
    end
  end

endmodule

// ===== src/envelope_header_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// envelope_header_tokenizer_unit
// Splits a header byte stream into key bytes, value bytes and markers.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_data_byte
//   out      output     out_valid / out_ready out_kind, out_byte, out_last
//
// one byte is taken per cycle while in_ready is high; its results are written
// to a four-entry queue in the same cycle and leave it one per cycle from the
// next cycle on while out_ready is high; the two results of one byte leave in
// turn. in_ready falls while the queue holds more than two results.
// synchronous reset returns the tokenizer to line start and empties the queue.
// ----------------------------------------------------------------------------
module envelope_header_tokenizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  ehtok_pkg::state_t  state_r, state_nxt;
  ehtok_pkg::state_t  step_nxt;
  ehtok_pkg::pair_t   step_res;
  ehtok_pkg::result_t head;
  logic               room;
  logic               accept;

  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  ehtok_decode u_decode (
    .st     (state_r),
    .b      (in_data_byte),
    .st_nxt (step_nxt),
    .res    (step_res)
  );

  assign state_nxt = accept ? step_nxt : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: ehtok_pkg::PH_START, cr_pending: 1'b0,
                   header_open: 1'b0, line_first_pending: 1'b0};
    end else begin
      state_r <= state_nxt;
    end
  end

  ehtok_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (accept),
    .push_data (step_res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  assign out_kind = head.kind;
  assign out_byte = head.data;
  assign out_last = head.last;

endmodule

// ===== tb/envelope_header_tokenizer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// envelope_header_tokenizer_unit_tb
// Self-checking bench for the envelope header tokenizer. Header lines,
// continuation lines and stray CRs are streamed in with random gaps and
// receiver stalls. Every byte is run through a local tokenizer model and the
// results are checked in order. The envelope ends once per run, through
// a randomly chosen close or error case, and the bytes after it must give
// no results.
// ----------------------------------------------------------------------------
module envelope_header_tokenizer_unit_tb;

  typedef logic [7:0] byte_q_t[$];

  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  // tokenizer model state
  ehtok_pkg::phase_t ph = ehtok_pkg::PH_START;
  logic   crp = 1'b0;
  logic   hopen = 1'b0;
  logic   lfp = 1'b0;

  ehtok_pkg::result_t step_res[$];
  ehtok_pkg::result_t pending_tokens[$];
  ehtok_pkg::result_t head_tok;

  int    items_sent = 0;
  int    mismatches = 0;
  int    kind_seen[5] = '{default: 0};
  int    quiet_cycles = 0;
  bit    tx_calm = 1'b0;
  bit    rx_calm = 1'b0;
  int    hold_req = 0;
  int    hold_left = 0;
  int    rx_wait = 0;
  string close_name = "none";

  envelope_header_tokenizer_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------- tokenizer model ----------------
  function automatic void note(ehtok_pkg::kind_t k, logic [7:0] d);
    ehtok_pkg::result_t r;
    r.kind = k;
    r.data = d;
    r.last = 1'b0;
    if (step_res.size() < 2) step_res.push_back(r);
  endfunction

  function automatic void note_value(logic [7:0] d);
    if (hopen) note(ehtok_pkg::K_VALUE, d);
  endfunction

  function automatic void abort_envelope();
    note(ehtok_pkg::K_ERR, 8'h00);
    ph = ehtok_pkg::PH_DONE;
    crp = 1'b0;
    lfp = 1'b0;
  endfunction

  function automatic void take_value(logic [7:0] b);
    ph = ehtok_pkg::PH_VALUE;
    if (b == ehtok_pkg::CH_CR) crp = 1'b1;
    else note_value(b);
  endfunction

  function automatic void line_break();
    ph = ehtok_pkg::PH_START;
    crp = 1'b0;
    lfp = 1'b0;
  endfunction

  function automatic void tokenize_byte(logic [7:0] b);
    step_res.delete();
    case (ph)
      ehtok_pkg::PH_START: begin
        if (lfp) begin
          lfp = 1'b0;
          if (b == ehtok_pkg::CH_LF) begin
            if (hopen) note(ehtok_pkg::K_HDR, 8'h00);
            note(ehtok_pkg::K_END, 8'h00);
            hopen = 1'b0;
            ph = ehtok_pkg::PH_DONE;
          end else if (!hopen) begin
            abort_envelope();
          end else begin
            note_value(ehtok_pkg::CH_CR);
            take_value(b);
          end
        end else if (b == ehtok_pkg::CH_CR) begin
          lfp = 1'b1;
        end else if (b <= ehtok_pkg::CH_SPACE) begin
          if (!hopen) abort_envelope();
          else take_value(b);
        end else begin
          if (hopen) note(ehtok_pkg::K_HDR, 8'h00);
          if (b == ehtok_pkg::CH_COLON) begin
            hopen = 1'b0;
            ph = ehtok_pkg::PH_SKIP;
          end else begin
            hopen = 1'b1;
            note(ehtok_pkg::K_KEY, b);
            ph = ehtok_pkg::PH_KEY;
          end
        end
      end
      ehtok_pkg::PH_KEY: begin
        if (crp && b == ehtok_pkg::CH_LF) begin
          abort_envelope();
        end else begin
          if (crp) begin
            note(ehtok_pkg::K_KEY, ehtok_pkg::CH_CR);
            crp = 1'b0;
          end
          if (b == ehtok_pkg::CH_CR) crp = 1'b1;
          else if (b == ehtok_pkg::CH_COLON) ph = ehtok_pkg::PH_SKIP;
          else note(ehtok_pkg::K_KEY, b);
        end
      end
      ehtok_pkg::PH_SKIP: begin
        if (crp) begin
          crp = 1'b0;
          if (b == ehtok_pkg::CH_LF) line_break();
          else take_value(b);
        end else if (b == ehtok_pkg::CH_CR) begin
          crp = 1'b1;
        end else begin
          ph = ehtok_pkg::PH_VALUE;
        end
      end
      ehtok_pkg::PH_VALUE: begin
        if (crp && b == ehtok_pkg::CH_LF) begin
          line_break();
        end else begin
          if (crp) begin
            crp = 1'b0;
            note_value(ehtok_pkg::CH_CR);
          end
          take_value(b);
        end
      end
      default: ph = ehtok_pkg::PH_DONE;
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) pending_tokens.push_back(step_res[i]);
  endfunction

  // ---------------- stimulus ----------------
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tokenize_byte(b);
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_seq(input byte_q_t s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
  endtask

  // random byte that never closes a line: no lf right after a cr
  function automatic logic [7:0] line_byte(bit prev_cr);
    logic [7:0] b;
    if ($urandom_range(0, 11) == 0) b = ehtok_pkg::CH_CR;
    else b = $urandom_range(0, 255);
    if (prev_cr && b == ehtok_pkg::CH_LF) b = 8'h4C;
    return b;
  endfunction

  task automatic send_random_line();
    logic [7:0] b;
    bit         prev_cr;
    int         n;
    prev_cr = 1'b0;
    if (hopen && $urandom_range(0, 3) == 0) begin
      b = $urandom_range(0, ehtok_pkg::CH_SPACE);
      send_byte(b);
      prev_cr = (b == ehtok_pkg::CH_CR);
    end else begin
      if ($urandom_range(0, 15) == 0) begin
        b = ehtok_pkg::CH_COLON;
      end else begin
        b = $urandom_range(8'h21, 8'hFF);
        if (b == ehtok_pkg::CH_COLON) b = 8'h3B;
      end
      send_byte(b);
      if (b != ehtok_pkg::CH_COLON) begin
        n = $urandom_range(0, 6);
        repeat (n) begin
          b = line_byte(prev_cr);
          send_byte(b);
          prev_cr = (b == ehtok_pkg::CH_CR);
        end
        send_byte(ehtok_pkg::CH_COLON);
        prev_cr = 1'b0;
      end
    end
    n = $urandom_range(0, 10);
    repeat (n) begin
      b = line_byte(prev_cr);
      send_byte(b);
      prev_cr = (b == ehtok_pkg::CH_CR);
    end
    send_byte(ehtok_pkg::CH_CR);
    send_byte(ehtok_pkg::CH_LF);
  endtask

  // ---------------- tests ----------------
  task automatic test_directed_lines();
    byte_q_t s;
    s = '{8'h21, 8'hFF, ehtok_pkg::CH_COLON, ehtok_pkg::CH_SPACE, 8'h00, 8'hFF,
          ehtok_pkg::CH_CR, ehtok_pkg::CH_LF,
          ehtok_pkg::CH_LF, 8'h78, ehtok_pkg::CH_CR, ehtok_pkg::CH_LF,
          ehtok_pkg::CH_CR, 8'h79, ehtok_pkg::CH_CR, ehtok_pkg::CH_LF,
          8'h6B, ehtok_pkg::CH_COLON, ehtok_pkg::CH_CR, ehtok_pkg::CH_LF,
          ehtok_pkg::CH_COLON, 8'h7A, 8'h71, ehtok_pkg::CH_CR, ehtok_pkg::CH_LF};
    send_seq(s);
  endtask

  task automatic test_random_lines(input int count);
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) send_random_line();
  endtask

  task automatic test_streaming();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    test_random_lines(250);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_backpressure();
    tx_calm = 1'b1;
    hold_req = 300;
    test_random_lines(60);
    tx_calm = 1'b0;
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (4) begin
      test_random_lines(20);
      wait_drained();
    end
  endtask

  task automatic test_envelope_close();
    byte_q_t s;
    case ($urandom_range(0, 4))
      0: begin
        close_name = "blank line";
        s = '{ehtok_pkg::CH_CR, ehtok_pkg::CH_LF};
      end
      1: begin
        close_name = "blank line after empty key";
        s = '{ehtok_pkg::CH_COLON, 8'h78, ehtok_pkg::CH_CR, ehtok_pkg::CH_LF,
              ehtok_pkg::CH_CR, ehtok_pkg::CH_LF};
      end
      2: begin
        close_name = "continuation without open header";
        s = '{ehtok_pkg::CH_COLON, 8'h78, ehtok_pkg::CH_CR, ehtok_pkg::CH_LF,
              ehtok_pkg::CH_SPACE};
      end
      3: begin
        close_name = "key line without colon";
        s = '{8'h61, 8'h62, ehtok_pkg::CH_CR, ehtok_pkg::CH_LF};
      end
      default: begin
        close_name = "cr line start without open header";
        s = '{ehtok_pkg::CH_COLON, ehtok_pkg::CH_CR, ehtok_pkg::CH_LF,
              ehtok_pkg::CH_CR, 8'h71};
      end
    endcase
    send_seq(s);
    // everything after the close is ignored
    repeat (8) send_byte($urandom_range(0, 255));
  endtask

  // ---------------- receiver ----------------
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 2) == 0) begin
      rx_wait = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------- result check ----------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d byte %02h last %0d",
                   out_kind, out_byte, out_last);
      end else begin
        head_tok = pending_tokens.pop_front();
        if (out_kind !== head_tok.kind || out_byte !== head_tok.data ||
            out_last !== head_tok.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected kind %0d byte %02h last %0d, ",
                      "got kind %0d byte %02h last %0d"},
                     head_tok.kind, head_tok.data, head_tok.last,
                     out_kind, out_byte, out_last);
        end
        if (out_kind <= 3'd4) kind_seen[out_kind]++;
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[envelope_header_tokenizer_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_lines();
    test_random_lines(1300);
    test_streaming();
    test_backpressure();
    test_drain_pause();
    test_random_lines(120);
    test_envelope_close();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d items: %0d key, %0d value, %0d header complete results",
             items_sent, kind_seen[ehtok_pkg::K_KEY], kind_seen[ehtok_pkg::K_VALUE],
             kind_seen[ehtok_pkg::K_HDR]);
    $display("envelope closed by %s (%0d end, %0d error)",
             close_name, kind_seen[ehtok_pkg::K_END], kind_seen[ehtok_pkg::K_ERR]);
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("[envelope_header_tokenizer_unit] OK");
    end else begin
      $display("[envelope_header_tokenizer_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== envelope_header_tokenizer_unit.f =====
src/ehtok_pkg.sv
src/ehtok_decode.sv
src/ehtok_queue.sv
src/envelope_header_tokenizer_unit.sv
tb/envelope_header_tokenizer_unit_tb.sv
